// ===== design/mpm_pkg.sv =====
// Shared types and constants for the multi-pattern matcher.
// Used by mpm_engine, the top level and the testbench; depends on nothing else.
package mpm_pkg;

    // Default sizes of the automaton.
    localparam int DEF_MAX_NODES     = 256;
    localparam int DEF_MAX_PATTERNS  = 64;
    localparam int DEF_SYMBOL_BITS   = 8;
    localparam int DEF_POSITION_BITS = 32;

    // Depth of the command queue and of the result queue.
    localparam int QUEUE_DEPTH = 4;

    // Fixed field widths of the ports.
    localparam int CMD_W   = 2;
    localparam int SYM_W   = 8;
    localparam int ID_W    = 6;
    localparam int KIND_W  = 2;
    localparam int START_W = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_END   = 2'd1,
        CMD_BUILD = 2'd2,
        CMD_TEXT  = 2'd3
    } t_cmd;

    typedef enum logic [KIND_W-1:0] {
        KIND_MATCH  = 2'd0,
        KIND_FULL   = 2'd1,
        KIND_REUSED = 2'd2
    } t_kind;

    typedef struct packed {
        t_cmd             cmd;
        logic [SYM_W-1:0] symbol;
        logic [ID_W-1:0]  pattern_id;
    } t_item;

    typedef struct packed {
        t_kind              kind;
        logic [ID_W-1:0]    match_pattern;
        logic [START_W-1:0] start_pos;
        logic               last;
    } t_result;

endpackage

// ===== design/mpm_fifo.sv =====
// Small first-in first-out queue of register stages.
// Used for the command queue and the result queue; no package needed.
module mpm_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_head, r_tail;
    logic [AW:0]   r_count;
    logic          do_push, do_pop;

    assign o_full  = (int'(r_count) == DEPTH);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_head];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Storage stages.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_tail] <= i_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_tail <= (int'(r_tail) == DEPTH - 1) ? '0 : r_tail + 1'b1;
            end
            if (do_pop) begin
                r_head <= (int'(r_head) == DEPTH - 1) ? '0 : r_head + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== design/mpm_engine.sv =====
// Back end of the matcher: sequencer over the trie and link memories.
// Depends on mpm_pkg; takes items from the command queue, gives results.
module mpm_engine #(
    parameter int MAX_NODES     = mpm_pkg::DEF_MAX_NODES,
    parameter int MAX_PATTERNS  = mpm_pkg::DEF_MAX_PATTERNS,
    parameter int SYMBOL_BITS   = mpm_pkg::DEF_SYMBOL_BITS,
    parameter int POSITION_BITS = mpm_pkg::DEF_POSITION_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_item_valid,
    input  mpm_pkg::t_item  i_item,
    output logic            o_item_pop,
    output logic            o_clearing,
    output logic            o_res_push,
    output mpm_pkg::t_result o_res,
    input  logic            i_res_full
);
    import mpm_pkg::*;

    localparam int NW    = $clog2(MAX_NODES);
    localparam int SB    = SYMBOL_BITS;
    localparam int TW    = NW + SB;
    localparam int NSYM  = 1 << SB;
    localparam int TBL_N = MAX_NODES * NSYM;
    localparam int PW    = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
    localparam int CWN   = $clog2(MAX_NODES + 1);
    localparam int CWP   = $clog2(MAX_PATTERNS + 1);
    localparam int CLR_N = (TBL_N > MAX_PATTERNS) ? TBL_N : MAX_PATTERNS;
    localparam int CLRW  = $clog2(CLR_N + 1);
    localparam int PB    = POSITION_BITS;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_ADD_T, S_ADD_C, S_END_C, S_END_F, S_END_W,
        S_BLD_SYM, S_BLD_E, S_BLD_V, S_BLD_L, S_BLD_POP, S_BLD_U, S_BLD_F,
        S_TXT_T, S_TXT_V, S_TXT_P, S_TXT_N, S_FINISH
    } t_state;

    // Memories: table entry is {valid, node}, pattern ref is {valid, id}.
    logic [NW:0]   m_tbl [TBL_N];
    logic [NW-1:0] m_dep [MAX_NODES];
    logic [NW-1:0] m_fl  [MAX_NODES];
    logic [NW-1:0] m_ol  [MAX_NODES];
    logic [PW:0]   m_fp  [MAX_NODES];
    logic [PW:0]   m_np  [MAX_PATTERNS];
    logic          m_pu  [MAX_PATTERNS];
    logic [NW-1:0] m_bq  [MAX_NODES];

    logic          tbl_we, dep_we, fl_we, ol_we, fp_we, np_we, pu_we, bq_we;
    logic [TW-1:0] tbl_wa, tbl_ra;
    logic [NW:0]   tbl_wd, tbl_rd;
    logic [NW-1:0] dep_wa, dep_ra, dep_wd, dep_rd;
    logic [NW-1:0] fl_wa, fl_ra, fl_wd, fl_rd;
    logic [NW-1:0] ol_wa, ol_ra, ol_wd, ol_rd;
    logic [NW-1:0] fp_wa, fp_ra;
    logic [PW:0]   fp_wd, fp_rd;
    logic [PW-1:0] np_wa, np_ra;
    logic [PW:0]   np_wd, np_rd;
    logic [PW-1:0] pu_wa, pu_ra;
    logic          pu_wd, pu_rd;
    logic [NW-1:0] bq_wa, bq_ra, bq_wd, bq_rd;

    // Control registers and their next values.
    t_state        r_state, n_state;
    logic [CLRW-1:0] r_clr, n_clr;
    logic [CWN-1:0] r_niu, n_niu;
    logic [NW-1:0] r_cursor, n_cursor, r_cur_dep, n_cur_dep;
    logic          r_ovf, n_ovf, r_ovf_s, n_ovf_s;
    logic [NW-1:0] r_cur, n_cur;
    logic [PB-1:0] r_pos, n_pos;
    t_item         r_item, n_item;
    logic [NW-1:0] r_node, n_node, r_fu, n_fu, r_du, n_du, r_t, n_t;
    logic [SB-1:0] r_sym, n_sym;
    logic [NW:0]   r_e, n_e, r_via, n_via;
    logic [CWN-1:0] r_head, n_head, r_tail, n_tail, r_hops, n_hops;
    logic          r_root, n_root;
    logic [PW:0]   r_p, n_p;
    logic [NW-1:0] r_vdep, n_vdep, r_vout, n_vout;
    logic [CWP-1:0] r_n, n_n;
    t_result       r_pend, n_pend;
    logic          r_pend_v, n_pend_v;

    logic [PW-1:0] pid;
    logic [SB-1:0] isym;
    logic [NW:0]   via;
    logic [NW-1:0] f_node, v_node;
    logic          last_sym;

    assign pid        = PW'(r_item.pattern_id);
    assign isym       = i_item.symbol[SB-1:0];
    assign o_clearing = (r_state == S_CLEAR);
    assign last_sym   = (int'(r_sym) == NSYM - 1);

    // Sequencer: next state, memory accesses and result pushes.
    always_comb begin
        n_state = r_state;  n_clr = r_clr;      n_niu = r_niu;
        n_cursor = r_cursor; n_cur_dep = r_cur_dep;
        n_ovf = r_ovf;      n_ovf_s = r_ovf_s;  n_cur = r_cur;
        n_pos = r_pos;      n_item = r_item;    n_node = r_node;
        n_fu = r_fu;        n_du = r_du;        n_t = r_t;
        n_sym = r_sym;      n_e = r_e;          n_via = r_via;
        n_head = r_head;    n_tail = r_tail;    n_hops = r_hops;
        n_root = r_root;    n_p = r_p;          n_vdep = r_vdep;
        n_vout = r_vout;    n_n = r_n;          n_pend = r_pend;
        n_pend_v = r_pend_v;
        tbl_we = 1'b0; tbl_wa = '0; tbl_wd = '0; tbl_ra = '0;
        dep_we = 1'b0; dep_wa = '0; dep_wd = '0; dep_ra = '0;
        fl_we = 1'b0;  fl_wa = '0;  fl_wd = '0;  fl_ra = '0;
        ol_we = 1'b0;  ol_wa = '0;  ol_wd = '0;  ol_ra = '0;
        fp_we = 1'b0;  fp_wa = '0;  fp_wd = '0;  fp_ra = '0;
        np_we = 1'b0;  np_wa = '0;  np_wd = '0;  np_ra = '0;
        pu_we = 1'b0;  pu_wa = '0;  pu_wd = 1'b0; pu_ra = '0;
        bq_we = 1'b0;  bq_wa = '0;  bq_wd = '0;  bq_ra = '0;
        o_item_pop = 1'b0;
        o_res_push = 1'b0;
        o_res      = r_pend;
        o_res.last = 1'b0;
        via    = r_root ? {1'b1, NW'(0)} : tbl_rd;
        f_node = r_via[NW-1:0];
        v_node = tbl_rd[NW:NW] != 1'b0 ? tbl_rd[NW-1:0] : '0;

        case (r_state)
            // Sweep every store that reset must clear, one entry a cycle.
            S_CLEAR: begin
                if (int'(r_clr) < TBL_N) begin
                    tbl_we = 1'b1;
                    tbl_wa = r_clr[TW-1:0];
                end
                if (int'(r_clr) < MAX_NODES) begin
                    dep_we = 1'b1; dep_wa = r_clr[NW-1:0];
                    fl_we  = 1'b1; fl_wa  = r_clr[NW-1:0];
                    ol_we  = 1'b1; ol_wa  = r_clr[NW-1:0];
                    fp_we  = 1'b1; fp_wa  = r_clr[NW-1:0];
                end
                if (int'(r_clr) < MAX_PATTERNS) begin
                    pu_we = 1'b1;
                    pu_wa = r_clr[PW-1:0];
                end
                n_clr = r_clr + 1'b1;
                if (int'(r_clr) == CLR_N - 1) begin
                    n_state = S_IDLE;
                end
            end
            // Take the next command and start its first memory read.
            S_IDLE: begin
                if (i_item_valid) begin
                    o_item_pop = 1'b1;
                    n_item     = i_item;
                    case (i_item.cmd)
                        CMD_ADD: begin
                            tbl_ra = {r_cursor, isym};
                            if (!r_ovf) begin
                                n_state = S_ADD_T;
                            end
                        end
                        CMD_END: begin
                            pu_ra     = PW'(i_item.pattern_id);
                            n_node    = r_cursor;
                            n_ovf_s   = r_ovf;
                            n_cursor  = '0;
                            n_cur_dep = '0;
                            n_ovf     = 1'b0;
                            n_state   = S_END_C;
                        end
                        CMD_BUILD: begin
                            fl_we = 1'b1; fl_wa = '0; fl_wd = '0;
                            ol_we = 1'b1; ol_wa = '0; ol_wd = '0;
                            n_node = '0; n_fu = '0; n_du = '0;
                            n_root = 1'b1; n_sym = '0;
                            n_head = '0; n_tail = '0;
                            n_state = S_BLD_SYM;
                        end
                        default: begin
                            tbl_ra  = {r_cur, isym};
                            n_n     = '0;
                            n_hops  = '0;
                            n_state = S_TXT_T;
                        end
                    endcase
                end
            end
            // Pattern symbol: look up the edge, then the target's depth.
            S_ADD_T: begin
                n_e     = tbl_rd;
                dep_ra  = tbl_rd[NW-1:0];
                n_state = S_ADD_C;
            end
            S_ADD_C: begin
                n_state = S_IDLE;
                if (r_e[NW] && {1'b0, dep_rd} == {1'b0, r_cur_dep} + 1'b1) begin
                    n_cursor  = r_e[NW-1:0];
                    n_cur_dep = dep_rd;
                end else if (int'(r_niu) >= MAX_NODES) begin
                    n_ovf = 1'b1;
                end else begin
                    dep_we = 1'b1; dep_wa = r_niu[NW-1:0]; dep_wd = r_cur_dep + 1'b1;
                    fl_we  = 1'b1; fl_wa  = r_niu[NW-1:0];
                    ol_we  = 1'b1; ol_wa  = r_niu[NW-1:0];
                    fp_we  = 1'b1; fp_wa  = r_niu[NW-1:0];
                    tbl_we = 1'b1;
                    tbl_wa = {r_cursor, r_item.symbol[SB-1:0]};
                    tbl_wd = {1'b1, r_niu[NW-1:0]};
                    n_cursor  = r_niu[NW-1:0];
                    n_cur_dep = r_cur_dep + 1'b1;
                    n_niu     = r_niu + 1'b1;
                end
            end
            // End of pattern: check for errors, then append to the node's list.
            S_END_C: begin
                if (r_ovf_s) begin
                    n_pend   = '{KIND_FULL, r_item.pattern_id, '0, 1'b0};
                    n_pend_v = 1'b1;
                    n_state  = S_FINISH;
                end else if (int'(r_item.pattern_id) >= MAX_PATTERNS || pu_rd) begin
                    n_pend   = '{KIND_REUSED, r_item.pattern_id, '0, 1'b0};
                    n_pend_v = 1'b1;
                    n_state  = S_FINISH;
                end else begin
                    pu_we = 1'b1; pu_wa = pid; pu_wd = 1'b1;
                    np_we = 1'b1; np_wa = pid; np_wd = '0;
                    fp_ra = r_node;
                    n_state = S_END_F;
                end
            end
            S_END_F: begin
                if (!fp_rd[PW]) begin
                    fp_we = 1'b1; fp_wa = r_node; fp_wd = {1'b1, pid};
                    n_state = S_IDLE;
                end else begin
                    n_p     = fp_rd;
                    np_ra   = fp_rd[PW-1:0];
                    n_state = S_END_W;
                end
            end
            S_END_W: begin
                if (!np_rd[PW]) begin
                    np_we = 1'b1; np_wa = r_p[PW-1:0]; np_wd = {1'b1, pid};
                    n_state = S_IDLE;
                end else begin
                    n_p   = np_rd;
                    np_ra = np_rd[PW-1:0];
                end
            end
            // Build: per node and symbol, read own edge and the fallback edge.
            S_BLD_SYM: begin
                tbl_ra  = {r_node, r_sym};
                n_state = S_BLD_E;
            end
            S_BLD_E: begin
                n_e     = tbl_rd;
                dep_ra  = tbl_rd[NW-1:0];
                tbl_ra  = {r_fu, r_sym};
                n_state = S_BLD_V;
            end
            S_BLD_V: begin
                n_via = via;
                if (r_e[NW] && {1'b0, dep_rd} == {1'b0, r_du} + 1'b1) begin
                    n_t     = r_e[NW-1:0];
                    fp_ra   = via[NW-1:0];
                    ol_ra   = via[NW-1:0];
                    n_state = S_BLD_L;
                end else begin
                    tbl_we = 1'b1; tbl_wa = {r_node, r_sym}; tbl_wd = via;
                    n_sym   = r_sym + 1'b1;
                    n_state = last_sym ? S_BLD_POP : S_BLD_SYM;
                end
            end
            S_BLD_L: begin
                fl_we = 1'b1; fl_wa = r_t; fl_wd = f_node;
                ol_we = 1'b1; ol_wa = r_t;
                ol_wd = (f_node != '0 && fp_rd[PW]) ? f_node : ol_rd;
                if (int'(r_tail) < MAX_NODES) begin
                    bq_we  = 1'b1;
                    bq_wa  = r_tail[NW-1:0];
                    bq_wd  = r_t;
                    n_tail = r_tail + 1'b1;
                end
                n_sym   = r_sym + 1'b1;
                n_state = last_sym ? S_BLD_POP : S_BLD_SYM;
            end
            S_BLD_POP: begin
                if (r_head == r_tail) begin
                    n_cur   = '0;
                    n_pos   = '0;
                    n_state = S_IDLE;
                end else begin
                    bq_ra   = r_head[NW-1:0];
                    n_head  = r_head + 1'b1;
                    n_state = S_BLD_U;
                end
            end
            S_BLD_U: begin
                n_node  = bq_rd;
                fl_ra   = bq_rd;
                dep_ra  = bq_rd;
                n_state = S_BLD_F;
            end
            S_BLD_F: begin
                n_fu    = fl_rd;
                n_du    = dep_rd;
                n_root  = 1'b0;
                n_sym   = '0;
                n_state = S_BLD_SYM;
            end
            // Text symbol: take the transition, then walk the output chain.
            S_TXT_T: begin
                n_cur  = v_node;
                n_node = v_node;
                fp_ra  = v_node;
                dep_ra = v_node;
                ol_ra  = v_node;
                n_state = (v_node == '0) ? S_FINISH : S_TXT_V;
            end
            S_TXT_V: begin
                n_p     = fp_rd;
                n_vdep  = dep_rd;
                n_vout  = ol_rd;
                n_state = S_TXT_P;
            end
            S_TXT_P: begin
                if (r_p[PW] && int'(r_n) < MAX_PATTERNS) begin
                    // The held result goes out once the next one is known.
                    if (r_pend_v) begin
                        o_res_push = !i_res_full;
                    end
                    if (!r_pend_v || !i_res_full) begin
                        n_pend   = '{KIND_MATCH, ID_W'(r_p[PW-1:0]),
                                     START_W'(r_pos + 1'b1 - PB'(r_vdep)), 1'b0};
                        n_pend_v = 1'b1;
                        n_n      = r_n + 1'b1;
                        np_ra    = r_p[PW-1:0];
                        n_state  = S_TXT_N;
                    end
                end else begin
                    n_hops = r_hops + 1'b1;
                    n_node = r_vout;
                    fp_ra  = r_vout;
                    dep_ra = r_vout;
                    ol_ra  = r_vout;
                    if (r_vout == '0 || int'(r_hops) + 1 >= MAX_NODES ||
                        int'(r_n) >= MAX_PATTERNS) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_TXT_V;
                    end
                end
            end
            S_TXT_N: begin
                n_p     = np_rd;
                n_state = S_TXT_P;
            end
            // Release the held result as the final one of this command.
            S_FINISH: begin
                o_res.last = 1'b1;
                if (!r_pend_v || !i_res_full) begin
                    o_res_push = r_pend_v;
                    n_pend_v   = 1'b0;
                    n_state    = S_IDLE;
                    if (r_item.cmd == CMD_TEXT) begin
                        n_pos = r_pos + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_niu    <= CWN'(1);
            r_cursor <= '0;
            r_cur_dep <= '0;
            r_ovf    <= 1'b0;
            r_cur    <= '0;
            r_pos    <= '0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_niu    <= n_niu;
            r_cursor <= n_cursor;
            r_cur_dep <= n_cur_dep;
            r_ovf    <= n_ovf;
            r_cur    <= n_cur;
            r_pos    <= n_pos;
            r_pend_v <= n_pend_v;
        end
    end

    // Working registers of the sequencer.
    always_ff @(posedge i_clk) begin
        r_ovf_s <= n_ovf_s; r_item <= n_item; r_node <= n_node;
        r_fu <= n_fu; r_du <= n_du; r_t <= n_t; r_sym <= n_sym;
        r_e <= n_e; r_via <= n_via; r_head <= n_head; r_tail <= n_tail;
        r_hops <= n_hops; r_root <= n_root; r_p <= n_p; r_vdep <= n_vdep;
        r_vout <= n_vout; r_n <= n_n; r_pend <= n_pend;
    end

    // Memories with registered read data.
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            m_tbl[tbl_wa] <= tbl_wd;
        end
        tbl_rd <= m_tbl[tbl_ra];
    end
    always_ff @(posedge i_clk) begin
        if (dep_we) begin
            m_dep[dep_wa] <= dep_wd;
        end
        dep_rd <= m_dep[dep_ra];
    end
    always_ff @(posedge i_clk) begin
        if (fl_we) begin
            m_fl[fl_wa] <= fl_wd;
        end
        fl_rd <= m_fl[fl_ra];
    end
    always_ff @(posedge i_clk) begin
        if (ol_we) begin
            m_ol[ol_wa] <= ol_wd;
        end
        ol_rd <= m_ol[ol_ra];
    end
    always_ff @(posedge i_clk) begin
        if (fp_we) begin
            m_fp[fp_wa] <= fp_wd;
        end
        fp_rd <= m_fp[fp_ra];
    end
    always_ff @(posedge i_clk) begin
        if (np_we) begin
            m_np[np_wa] <= np_wd;
        end
        np_rd <= m_np[np_ra];
    end
    always_ff @(posedge i_clk) begin
        if (pu_we) begin
            m_pu[pu_wa] <= pu_wd;
        end
        pu_rd <= m_pu[pu_ra];
    end
    always_ff @(posedge i_clk) begin
        if (bq_we) begin
            m_bq[bq_wa] <= bq_wd;
        end
        bq_rd <= m_bq[bq_ra];
    end

`ifndef SYNTHESIS
    a_niu_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_niu != '0 && int'(r_niu) <= MAX_NODES)
        else $error("node count out of range");
    a_push_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_res_push && i_res_full))
        else $error("result pushed into a full queue");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_item_pop |-> r_state == S_IDLE)
        else $error("command taken while busy");
    a_cursor_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CWN'(r_cursor) < r_niu)
        else $error("load cursor beyond allocated nodes");
`endif

endmodule

// ===== design/multi_pattern_matcher_top.sv =====
// Top level of the Aho-Corasick multi-pattern matcher.
// Depends on mpm_pkg, mpm_fifo (command and result queues) and mpm_engine.
//
// Usage: commands enter through a queue port (push, full) with fields
// i_cmd, i_symbol and i_pattern_id; a transfer happens when push is high
// and full is low. Results leave through a queue port (empty, pop): the
// oldest result is on o_kind, o_match_pattern, o_start_pos and o_last while
// empty is low, and is transferred when pop is high.
// In the back end, add symbol reads the edge and then its target's depth;
// end pattern walks the patterns already at the node; text symbol takes
// the transition, then walks the output chain and each node's results;
// build visits each (node, symbol) pair and then each queued node.
// A four-entry command queue lets commands arrive while the back end works.
// After reset the transition table, node stores and pattern flags are swept
// clear, one entry a cycle, over MAX_NODES * 2^SYMBOL_BITS entries (or
// MAX_PATTERNS if larger); full stays high meanwhile.
// When the receiver stalls, the four-entry result queue fills, the back end
// holds, and then the command queue fills and raises full.
module multi_pattern_matcher_top #(
    parameter int MAX_NODES     = mpm_pkg::DEF_MAX_NODES,
    parameter int MAX_PATTERNS  = mpm_pkg::DEF_MAX_PATTERNS,
    parameter int SYMBOL_BITS   = mpm_pkg::DEF_SYMBOL_BITS,
    parameter int POSITION_BITS = mpm_pkg::DEF_POSITION_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [mpm_pkg::CMD_W-1:0]     i_cmd,
    input  logic [mpm_pkg::SYM_W-1:0]     i_symbol,
    input  logic [mpm_pkg::ID_W-1:0]      i_pattern_id,
    output logic                          empty,
    input  logic                          pop,
    output logic [mpm_pkg::KIND_W-1:0]    o_kind,
    output logic [mpm_pkg::ID_W-1:0]      o_match_pattern,
    output logic [mpm_pkg::START_W-1:0]   o_start_pos,
    output logic                          o_last
);
    import mpm_pkg::*;

    t_item   in_item, q_item;
    t_result eng_res, out_res;
    logic    in_full, q_empty, q_pop, clearing, res_push, res_full;

    // Command queue between the port and the back end.
    assign in_item = '{t_cmd'(i_cmd), i_symbol, i_pattern_id};
    assign full    = in_full || clearing;

    mpm_fifo #(.W($bits(t_item)), .DEPTH(QUEUE_DEPTH)) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && !full),
        .i_data  (in_item),
        .o_full  (in_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_item)
    );

    // Back end that runs each command.
    mpm_engine #(
        .MAX_NODES     (MAX_NODES),
        .MAX_PATTERNS  (MAX_PATTERNS),
        .SYMBOL_BITS   (SYMBOL_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (!q_empty),
        .i_item       (q_item),
        .o_item_pop   (q_pop),
        .o_clearing   (clearing),
        .o_res_push   (res_push),
        .o_res        (eng_res),
        .i_res_full   (res_full)
    );

    // Result queue towards the receiver.
    mpm_fifo #(.W($bits(t_result)), .DEPTH(QUEUE_DEPTH)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (eng_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (out_res)
    );

    assign o_kind          = out_res.kind;
    assign o_match_pattern = out_res.match_pattern;
    assign o_start_pos     = out_res.start_pos;
    assign o_last          = out_res.last;

endmodule

// ===== test/tb_multi_pattern_matcher_top.sv =====
// Self-checking testbench for the Aho-Corasick multi-pattern matcher top level.
// Depends on mpm_pkg and multi_pattern_matcher_top; a scoreboard class predicts every result.
module tb_multi_pattern_matcher_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mpm_pkg::*;

    localparam int NODES    = 256;
    localparam int PATTERNS = 64;
    localparam int IDLE_PCT = 31;
    localparam int HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 2000;

    // Scoreboard: an automaton that mirrors the block, and the queue of awaited results.
    class match_scoreboard;
        bit [8:0] goto_tbl [NODES*256];
        int       depth    [NODES];
        int       fail_lnk [NODES];
        int       out_lnk  [NODES];
        int       first_id [NODES];
        int       next_id  [PATTERNS];
        bit       id_taken [PATTERNS];
        int       node_cnt;
        int       cursor;
        bit       overflow;
        int       cur_node;
        bit [31:0] text_pos;
        t_result  awaited [$];
        int       errors;
        int       checked;

        function new();
            foreach (goto_tbl[i]) goto_tbl[i] = '0;
            foreach (depth[i]) begin
                depth[i] = 0; fail_lnk[i] = 0; out_lnk[i] = 0; first_id[i] = 0;
            end
            foreach (next_id[i]) begin
                next_id[i] = 0; id_taken[i] = 0;
            end
            node_cnt = 1; cursor = 0; overflow = 0; cur_node = 0; text_pos = '0;
            errors = 0; checked = 0;
        endfunction

        // Returns the child plus one when (node, sym) is a true trie edge, else zero.
        function int trie_edge(int node, int sym);
            bit [8:0] e;
            e = goto_tbl[node*256 + sym];
            if (e[8] && depth[e[7:0]] == depth[node] + 1) return int'(e[7:0]) + 1;
            return 0;
        endfunction

        function void expect_result(t_kind k, int id, bit [31:0] start, bit fin);
            t_result r;
            r.kind = k; r.match_pattern = id[5:0]; r.start_pos = start; r.last = fin;
            awaited.insert(awaited.size(), r);
        endfunction

        function void extend_trie(int sym);
            int c;
            int n;
            if (overflow) return;
            c = trie_edge(cursor, sym);
            if (c != 0) begin
                cursor = c - 1;
                return;
            end
            if (node_cnt >= NODES) begin
                overflow = 1;
                return;
            end
            n = node_cnt++;
            depth[n] = depth[cursor] + 1;
            fail_lnk[n] = 0; out_lnk[n] = 0; first_id[n] = 0;
            goto_tbl[cursor*256 + sym] = {1'b1, n[7:0]};
            cursor = n;
        endfunction

        function void close_pattern(int id);
            int node;
            int p;
            bit was_full;
            node = cursor; was_full = overflow;
            cursor = 0; overflow = 0;
            if (was_full) begin
                expect_result(KIND_FULL, id, '0, 1'b1);
                return;
            end
            if (id_taken[id]) begin
                expect_result(KIND_REUSED, id, '0, 1'b1);
                return;
            end
            id_taken[id] = 1;
            next_id[id] = 0;
            if (first_id[node] == 0) begin
                first_id[node] = id + 1;
                return;
            end
            // Append to the end of the list of patterns at this node.
            p = first_id[node] - 1;
            for (int g = 0; g < PATTERNS; g++) begin
                if (next_id[p] == 0) break;
                p = next_id[p] - 1;
            end
            next_id[p] = id + 1;
        endfunction

        // Breadth-first pass: failure links, output links and the full goto function.
        function void build_automaton();
            int fifo [NODES];
            int head;
            int tail;
            int u;
            int fu;
            int c;
            int f;
            bit [8:0] via;
            head = 0; tail = 0;
            fail_lnk[0] = 0; out_lnk[0] = 0;
            for (int s = 0; s < 256; s++) begin
                c = trie_edge(0, s);
                if (c != 0) begin
                    fail_lnk[c-1] = 0; out_lnk[c-1] = 0;
                    if (tail < NODES) fifo[tail++] = c - 1;
                end else begin
                    goto_tbl[s] = 9'h100;
                end
            end
            while (head < tail) begin
                u = fifo[head++];
                fu = fail_lnk[u];
                for (int s = 0; s < 256; s++) begin
                    c = trie_edge(u, s);
                    via = goto_tbl[fu*256 + s];
                    if (c != 0) begin
                        f = via[7:0];
                        fail_lnk[c-1] = f;
                        out_lnk[c-1] = (f != 0 && first_id[f] != 0) ? f : out_lnk[f];
                        if (tail < NODES) fifo[tail++] = c - 1;
                    end else begin
                        goto_tbl[u*256 + s] = via;
                    end
                end
            end
            cur_node = 0; text_pos = '0;
        endfunction

        function void scan_symbol(int sym);
            bit [8:0] e;
            int v;
            int p;
            int n;
            e = goto_tbl[cur_node*256 + sym];
            cur_node = e[8] ? int'(e[7:0]) : 0;
            v = cur_node; n = 0;
            for (int hops = 0; v != 0 && hops < NODES && n < PATTERNS; hops++) begin
                p = first_id[v];
                for (int g = 0; p != 0 && g < PATTERNS && n < PATTERNS; g++) begin
                    expect_result(KIND_MATCH, p - 1, text_pos + 32'd1 - depth[v], 1'b0);
                    n++;
                    p = next_id[p-1];
                end
                v = out_lnk[v];
            end
            text_pos = text_pos + 32'd1;
            if (n > 0) awaited[$].last = 1'b1;
        endfunction

        // Called for every command transfer.
        function void note_command(t_cmd cmd, int sym, int id);
            case (cmd)
                CMD_ADD:   extend_trie(sym);
                CMD_END:   close_pattern(id);
                CMD_BUILD: build_automaton();
                default:   scan_symbol(sym);
            endcase
        endfunction

        function void report(string what, logic [31:0] got, logic [31:0] want);
            $display("MISMATCH at %0t: %s got %0h, expected %0h", $realtime, what, got, want);
            errors++;
        endfunction

        // Called for every result transfer.
        function void check_result(t_result got);
            t_result want;
            checked++;
            if (awaited.size() == 0) begin
                report("unexpected result, kind", 32'(got.kind), 32'hffffffff);
                return;
            end
            want = awaited.pop_front();
            if (got.kind != want.kind) report("kind", 32'(got.kind), 32'(want.kind));
            if (got.match_pattern != want.match_pattern)
                report("match_pattern", 32'(got.match_pattern), 32'(want.match_pattern));
            if (got.start_pos != want.start_pos)
                report("start_pos", got.start_pos, want.start_pos);
            if (got.last != want.last) report("last", 32'(got.last), 32'(want.last));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic [1:0]  i_cmd = '0;
    logic [7:0]  i_symbol = '0;
    logic [5:0]  i_pattern_id = '0;
    logic        full;
    logic        empty;
    logic [1:0]  o_kind;
    logic [5:0]  o_match_pattern;
    logic [31:0] o_start_pos;
    logic        o_last;

    match_scoreboard sb = new();
    bit calm = 0;
    bit hold_go = 0;
    bit hold_done = 0;
    int sent = 0;
    int idle_cycles = 0;

    multi_pattern_matcher_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_cmd(i_cmd), .i_symbol(i_symbol), .i_pattern_id(i_pattern_id),
        .empty(empty), .pop(pop), .o_kind(o_kind), .o_match_pattern(o_match_pattern),
        .o_start_pos(o_start_pos), .o_last(o_last)
    );

    // Clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Monitor both ports at the rising edge and feed the scoreboard.
    always @(posedge i_clk) begin
        t_result r;
        if (i_rst_n && push && !full) sb.note_command(t_cmd'(i_cmd), i_symbol, i_pattern_id);
        if (i_rst_n && pop && !empty) begin
            r.kind = t_kind'(o_kind); r.match_pattern = o_match_pattern;
            r.start_pos = o_start_pos; r.last = o_last;
            sb.check_result(r);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: random pops, plus one long hold-off when asked.
    always begin
        @(negedge i_clk);
        if (hold_go && !hold_done) begin
            hold_done = 1;
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge i_clk);
        end else begin
            pop <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Offer one command and wait for its transfer.
    task automatic send(t_cmd cmd, int sym, int id);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_cmd <= cmd; i_symbol <= sym[7:0]; i_pattern_id <= id[5:0];
        forever begin
            @(posedge i_clk);
            if (!full) break;
        end
        sent++;
    endtask

    task automatic send_pattern(string s, int id);
        for (int i = 0; i < s.len(); i++) send(CMD_ADD, s[i], 0);
        send(CMD_END, 0, id);
    endtask

    function automatic int pick_symbol();
        return ($urandom_range(99) < 85) ? 97 + $urandom_range(3) : $urandom_range(255);
    endfunction

    // Stimulus: directed part, then random phases of patterns, builds and text.
    initial begin
        int len;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: shared prefixes, two patterns on one node, empty and reused ids.
        send_pattern("ab", 0);
        send_pattern("b", 63);
        send_pattern("bab", 1);
        send_pattern("ab", 2);
        send_pattern("", 3);
        send_pattern("c", 0);
        send(CMD_ADD, 8'hff, 0);
        send(CMD_END, 0, 42);
        send(CMD_BUILD, 0, 0);
        send(CMD_TEXT, "a", 0);
        send(CMD_TEXT, "b", 0);
        send(CMD_TEXT, "a", 0);
        send(CMD_TEXT, "b", 0);
        send(CMD_TEXT, 8'hff, 0);
        send(CMD_TEXT, 8'h00, 0);

        // Random phases of patterns, a build and a stretch of text.
        while (sent < 215) begin
            for (int p = $urandom_range(4, 1); p > 0; p--) begin
                len = ($urandom_range(19) == 0) ? 0 : $urandom_range(3, 1);
                for (int i = 0; i < len; i++) send(CMD_ADD, pick_symbol(), 0);
                send(CMD_END, 0, $urandom_range(63));
            end
            send(CMD_BUILD, 0, 0);
            calm = (sent > 110 && sent < 170);
            if (sent > 60) hold_go = 1;
            for (int t = $urandom_range(30, 15); t > 0; t--) begin
                if ($urandom_range(49) == 0) send(CMD_BUILD, 0, 0);
                else send(CMD_TEXT, pick_symbol(), 0);
            end
            calm = 0;
        end
        @(negedge i_clk);
        push <= 1'b0;

        // Drain everything still awaited, then let the block settle.
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Run covered %0d commands and %0d results over pattern loads, reused ids,",
                 sent, sb.checked);
        $display("repeated builds and text scans with random and long receiver stalls.");
        if (sb.errors == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

endmodule
